[rtl/fcfs_ec_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fcfs_ec_pkg;

    // Queue and building size.
    localparam int QUEUE_DEPTH = 16;
    localparam int FLOOR_COUNT = 32;

    // Field and counter widths.
    localparam int FLOOR_W = 5;
    localparam int PEND_W  = 5;
    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);

    // Item operation codes.
    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_TICK = 1'b1
    } opcode_t;

    // One queued request.
    typedef struct packed {
        logic [FLOOR_W-1:0] pickup;
        logic [FLOOR_W-1:0] dest;
    } req_entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic add_en;
        logic step_en;
        logic out_load;
        logic cfg_wr;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic again;
    } dp_status_t;

    // Limit a floor number to the top floor of the building.
    function automatic logic [FLOOR_W-1:0] clamp_floor(input logic [FLOOR_W-1:0] f);
        logic [FLOOR_W-1:0] top;
        top = FLOOR_W'(FLOOR_COUNT - 1);
        return (f > top) ? top : f;
    endfunction

    // Move one floor toward a target, or stay when already there.
    function automatic logic [FLOOR_W-1:0] step_toward(input logic [FLOOR_W-1:0] car,
                                                       input logic [FLOOR_W-1:0] target);
        logic [FLOOR_W-1:0] res;
        res = car;
        if (car < target) begin
            res = car + FLOOR_W'(1);
        end else if (car > target) begin
            res = car - FLOOR_W'(1);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/fcfs_ec_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module fcfs_ec_datapath
    import fcfs_ec_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire dp_cmd_t             cmd,
    output dp_status_t               status,
    input  wire logic [FLOOR_W-1:0]  cfg_floor,
    input  wire logic [FLOOR_W-1:0]  in_pickup,
    input  wire logic [FLOOR_W-1:0]  in_dest,
    output logic [FLOOR_W-1:0]       out_floor,
    output logic                     out_carrying,
    output logic                     out_idle,
    output logic                     out_dropped,
    output logic [PEND_W-1:0]        out_pending
);

    // Request storage, written at the tail and read at the head only.
    req_entry_t queue_mem [QUEUE_DEPTH];

    logic [IDX_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [FLOOR_W-1:0] car_reg, car_next;
    logic               deliv_reg, deliv_next;

    logic [FLOOR_W-1:0] floor_out_reg;
    logic               carrying_out_reg;
    logic               idle_out_reg;
    logic               dropped_out_reg;
    logic [PEND_W-1:0]  pending_out_reg;

    req_entry_t         head_entry;
    logic [CNT_W:0]     tail_sum;
    logic [IDX_W-1:0]   tail_idx;
    logic [IDX_W-1:0]   head_inc;
    logic               queue_full;
    logic               again;

    assign head_entry = queue_mem[head_reg];
    assign queue_full = (count_reg == CNT_W'(QUEUE_DEPTH));

    // Circular tail and head-advance positions.
    assign tail_sum = (CNT_W+1)'(head_reg) + (CNT_W+1)'(count_reg);
    assign tail_idx = (tail_sum >= (CNT_W+1)'(QUEUE_DEPTH)) ?
                      IDX_W'(tail_sum - (CNT_W+1)'(QUEUE_DEPTH)) : IDX_W'(tail_sum);
    assign head_inc = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + IDX_W'(1);

    // One step of the car schedule, plus queue append and configuration.
    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        car_next   = car_reg;
        deliv_next = deliv_reg;
        again      = 1'b0;
        if (cmd.cfg_wr) begin
            car_next = clamp_floor(cfg_floor);
        end else if (cmd.add_en) begin
            if (!queue_full) begin
                count_next = count_reg + CNT_W'(1);
            end
        end else if (cmd.step_en) begin
            priority if (count_reg == '0) begin
                deliv_next = 1'b0;
            end else if (deliv_reg && (car_reg == head_entry.dest)) begin
                // Drop-off done: retire and serve the next request next cycle.
                head_next  = head_inc;
                count_next = count_reg - CNT_W'(1);
                deliv_next = 1'b0;
                again      = (count_reg != CNT_W'(1));
            end else if (!deliv_reg && (car_reg != head_entry.pickup)) begin
                car_next = step_toward(car_reg, head_entry.pickup);
            end else if (car_reg == head_entry.dest) begin
                // Pickup floor equals the destination: retire without moving.
                head_next  = head_inc;
                count_next = count_reg - CNT_W'(1);
                deliv_next = 1'b0;
            end else begin
                deliv_next = 1'b1;
                car_next   = step_toward(car_reg, head_entry.dest);
            end
        end
    end

    assign status.again = again;

    // Control state of the car and the queue.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
            car_reg   <= clamp_floor('0);
            deliv_reg <= 1'b0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
            car_reg   <= car_next;
            deliv_reg <= deliv_next;
        end
    end

    // Request storage write.
    always_ff @(posedge aclk) begin
        if (cmd.add_en && !queue_full) begin
            queue_mem[tail_idx] <= '{pickup: clamp_floor(in_pickup),
                                     dest:   clamp_floor(in_dest)};
        end
    end

    // Result register, loaded with the state after the item.
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            floor_out_reg    <= car_next;
            carrying_out_reg <= deliv_next;
            idle_out_reg     <= (count_next == '0);
            dropped_out_reg  <= cmd.add_en && queue_full;
            pending_out_reg  <= PEND_W'(count_next);
        end
    end

    assign out_floor    = floor_out_reg;
    assign out_carrying = carrying_out_reg;
    assign out_idle     = idle_out_reg;
    assign out_dropped  = dropped_out_reg;
    assign out_pending  = pending_out_reg;

endmodule

`default_nettype wire

[rtl/fcfs_ec_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module fcfs_ec_ctrl
    import fcfs_ec_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_opcode,
    output logic             m_valid,
    input  wire logic        m_ready,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    output dp_cmd_t          cmd,
    input  wire dp_status_t  status,
    output logic             busy
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_TICK = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   accept;
    logic   is_add;

    // Take a new transaction when no tick is in progress and the result slot is empty or being emptied.
    assign s_ready   = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept    = s_valid && s_ready;
    assign is_add    = (opcode_t'(s_opcode) == OP_ADD);
    assign cfg_ready = 1'b1;
    assign busy      = (state_reg == ST_TICK);

    // Datapath commands.
    always_comb begin
        cmd.cfg_wr   = cfg_valid;
        cmd.add_en   = accept && is_add;
        cmd.step_en  = (state_reg == ST_TICK);
        cmd.out_load = (accept && is_add) || ((state_reg == ST_TICK) && !status.again);
    end

    // Next state: a tick stays in the step state while retirements chain.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && !is_add) begin
                    state_next = ST_TICK;
                end
            end
            ST_TICK: begin
                if (!status.again) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Result valid flag.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

[rtl/fcfs_elevator_controller_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// First-come-first-served elevator controller. An add transaction queues a
// pickup/destination pair (up to 16 pending; a full queue drops it and flags
// add_dropped). A tick transaction moves the car one floor toward the head
// request's pickup, then toward its destination, retiring it on the tick after
// arrival. Every transaction returns one status result with the car floor, the
// carrying flag, the idle flag and the pending count. An add's result is valid
// in the cycle after acceptance. A tick's result is loaded in the step state,
// which repeats when it retires a delivered request and goes on to the next
// one, since the request store is read at the head once per cycle; no input is
// taken while a tick is being worked out. A new transaction is taken while the
// previous result is being handed off. Writing cfg_start_floor moves the car to
// that floor at once; write it only while the block is idle.
module fcfs_elevator_controller_top
    import fcfs_ec_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [FLOOR_W-1:0]  cfg_start_floor,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_opcode,
    input  wire logic [FLOOR_W-1:0]  s_pickup_floor,
    input  wire logic [FLOOR_W-1:0]  s_dest_floor,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [FLOOR_W-1:0]       m_floor_now,
    output logic                     m_carrying,
    output logic                     m_queue_idle,
    output logic                     m_add_dropped,
    output logic [PEND_W-1:0]        m_pending_count
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       busy;

    fcfs_ec_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_opcode  (s_opcode),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cmd       (cmd),
        .status    (status),
        .busy      (busy)
    );

    fcfs_ec_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .cfg_floor    (cfg_start_floor),
        .in_pickup    (s_pickup_floor),
        .in_dest      (s_dest_floor),
        .out_floor    (m_floor_now),
        .out_carrying (m_carrying),
        .out_idle     (m_queue_idle),
        .out_dropped  (m_add_dropped),
        .out_pending  (m_pending_count)
    );

    // No new transaction is taken while a tick is still being worked out.
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !s_ready)
        else $error("input accepted during tick processing");

    // The idle flag agrees with the pending count.
    a_idle_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_queue_idle == (m_pending_count == '0)))
        else $error("queue_idle disagrees with pending_count");

    // A dropped add only happens with a full queue.
    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_add_dropped) |-> (m_pending_count == PEND_W'(QUEUE_DEPTH)))
        else $error("add dropped with room in the queue");

    // The car only carries while a request is pending.
    a_carry_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_carrying) |-> !m_queue_idle)
        else $error("carrying with an empty queue");

    // A tick never chains more than one retirement step.
    a_tick_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(busy) && busy) |=> !busy)
        else $error("tick processing exceeded two cycles");

endmodule

`default_nettype wire

[tb/fcfs_status_checker.sv]
`timescale 1ns / 1ps

// Watches the configuration, request and status channels of the elevator
// controller, keeps its own copy of the car and queue state, and compares
// every returned status transaction with the predicted one.
module fcfs_status_checker
    import fcfs_ec_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic [FLOOR_W-1:0] cfg_start_floor,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire logic               s_opcode,
    input  wire logic [FLOOR_W-1:0] s_pickup_floor,
    input  wire logic [FLOOR_W-1:0] s_dest_floor,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire logic [FLOOR_W-1:0] m_floor_now,
    input  wire logic               m_carrying,
    input  wire logic               m_queue_idle,
    input  wire logic               m_add_dropped,
    input  wire logic [PEND_W-1:0]  m_pending_count,
    output int                      err_count,
    output int                      outstanding,
    output int                      checked
);

    // One status transaction as the block should return it.
    typedef struct packed {
        logic [FLOOR_W-1:0] floor_now;
        logic               carrying;
        logic               queue_idle;
        logic               add_dropped;
        logic [PEND_W-1:0]  pending;
    } car_status_t;

    // Predicted car and request queue state.
    req_entry_t         waiting_req [QUEUE_DEPTH];
    logic [IDX_W-1:0]   head_slot;
    int unsigned        queued;
    logic [FLOOR_W-1:0] car_pos;
    logic               heading_to_dest;

    car_status_t        status_due [$];
    car_status_t        want_status;
    int                 fail_tally  = 0;
    int                 match_tally = 0;

    // Floors above the top of the building are pulled down to the top floor.
    function automatic logic [FLOOR_W-1:0] limit_floor(input logic [FLOOR_W-1:0] f);
        if (int'(f) > FLOOR_COUNT - 1) begin
            return FLOOR_W'(FLOOR_COUNT - 1);
        end
        return f;
    endfunction

    function automatic void move_car(input logic [FLOOR_W-1:0] target);
        if (car_pos < target) begin
            car_pos = car_pos + 1'b1;
        end else if (car_pos > target) begin
            car_pos = car_pos - 1'b1;
        end
    endfunction

    function automatic void retire_head();
        head_slot       = (int'(head_slot) == QUEUE_DEPTH - 1) ? '0 : head_slot + 1'b1;
        queued          = queued - 1;
        heading_to_dest = 1'b0;
    endfunction

    // One time step of the car: finish a delivery, then head for the pickup
    // or the destination of whatever request is now at the head.
    function automatic void advance_car();
        req_entry_t head;
        if (queued == 0) begin
            heading_to_dest = 1'b0;
            return;
        end
        head = waiting_req[head_slot];
        if (heading_to_dest && car_pos == head.dest) begin
            retire_head();
            if (queued == 0) begin
                return;
            end
            head = waiting_req[head_slot];
        end
        if (!heading_to_dest && car_pos != head.pickup) begin
            move_car(head.pickup);
            return;
        end
        // Standing on the pickup floor that is also the destination.
        if (car_pos == head.dest) begin
            retire_head();
            return;
        end
        heading_to_dest = 1'b1;
        move_car(head.dest);
    endfunction

    // Apply one accepted request transaction and return the status it yields.
    function automatic car_status_t apply_item(input logic op,
                                               input logic [FLOOR_W-1:0] pickup,
                                               input logic [FLOOR_W-1:0] dest);
        car_status_t      st;
        logic             dropped;
        logic [IDX_W-1:0] slot;
        dropped = 1'b0;
        if (opcode_t'(op) == OP_ADD) begin
            if (queued >= QUEUE_DEPTH) begin
                dropped = 1'b1;
            end else begin
                slot = IDX_W'((int'(head_slot) + queued) % QUEUE_DEPTH);
                waiting_req[slot].pickup = limit_floor(pickup);
                waiting_req[slot].dest   = limit_floor(dest);
                queued = queued + 1;
            end
        end else begin
            advance_car();
        end
        st.floor_now   = car_pos;
        st.carrying    = heading_to_dest;
        st.queue_idle  = (queued == 0);
        st.add_dropped = dropped;
        st.pending     = PEND_W'(queued);
        return st;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            fail_tally++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Returned status is compared before this edge's request is predicted,
    // since a result never leaves in the cycle its request is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            head_slot       = '0;
            queued          = 0;
            heading_to_dest = 1'b0;
            car_pos         = limit_floor('0);
            status_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (status_due.size() == 0) begin
                    fail_tally++;
                    $display("%0t: unexpected status, expected none, actual floor %0d",
                             $time, m_floor_now);
                end else begin
                    want_status = status_due.pop_front();
                    check_field("floor_now", 8'(want_status.floor_now), 8'(m_floor_now));
                    check_field("carrying", 8'(want_status.carrying), 8'(m_carrying));
                    check_field("queue_idle", 8'(want_status.queue_idle), 8'(m_queue_idle));
                    check_field("add_dropped", 8'(want_status.add_dropped), 8'(m_add_dropped));
                    check_field("pending_count", 8'(want_status.pending), 8'(m_pending_count));
                    match_tally++;
                end
            end
            // A start floor write moves the car but leaves the queue alone.
            if (cfg_valid && cfg_ready) begin
                car_pos = limit_floor(cfg_start_floor);
            end
            if (s_valid && s_ready) begin
                status_due.push_back(apply_item(s_opcode, s_pickup_floor, s_dest_floor));
            end
        end
        err_count   <= fail_tally;
        outstanding <= status_due.size();
        checked     <= match_tally;
    end

endmodule

[tb/tb_fcfs_elevator_controller_top.sv]
`timescale 1ns / 1ps

module tb_fcfs_elevator_controller_top;
    import fcfs_ec_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    logic               aclk            = 1'b0;
    logic               aresetn         = 1'b0;
    logic               cfg_valid       = 1'b0;
    logic               cfg_ready;
    logic [FLOOR_W-1:0] cfg_start_floor = '0;
    logic               s_valid         = 1'b0;
    logic               s_ready;
    logic               s_opcode        = OP_ADD;
    logic [FLOOR_W-1:0] s_pickup_floor  = '0;
    logic [FLOOR_W-1:0] s_dest_floor    = '0;
    logic               m_valid;
    logic               m_ready         = 1'b0;
    logic [FLOOR_W-1:0] m_floor_now;
    logic               m_carrying;
    logic               m_queue_idle;
    logic               m_add_dropped;
    logic [PEND_W-1:0]  m_pending_count;

    int err_count;
    int outstanding;
    int checked;

    int cycle_count = 0;
    int items_sent  = 0;
    int adds_sent   = 0;
    int ticks_sent  = 0;
    int cfg_writes  = 0;
    bit tx_calm     = 1'b0;

    int rx_hold  = 0;
    int rx_seen  = 0;
    bit rx_calm  = 1'b0;

    fcfs_elevator_controller_top DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_start_floor (cfg_start_floor),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_pickup_floor  (s_pickup_floor),
        .s_dest_floor    (s_dest_floor),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_floor_now     (m_floor_now),
        .m_carrying      (m_carrying),
        .m_queue_idle    (m_queue_idle),
        .m_add_dropped   (m_add_dropped),
        .m_pending_count (m_pending_count)
    );

    fcfs_status_checker status_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_start_floor (cfg_start_floor),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_pickup_floor  (s_pickup_floor),
        .s_dest_floor    (s_dest_floor),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_floor_now     (m_floor_now),
        .m_carrying      (m_carrying),
        .m_queue_idle    (m_queue_idle),
        .m_add_dropped   (m_add_dropped),
        .m_pending_count (m_pending_count),
        .err_count       (err_count),
        .outstanding     (outstanding),
        .checked         (checked)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Run guard: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Status receiver: after each transaction it stalls for a random number
    // of cycles, with calm stretches where it never stalls.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_hold = 0;
        end else if (rx_hold > 0) begin
            rx_hold--;
            if (rx_hold == 0) begin
                m_ready <= 1'b1;
            end
        end else if (!m_ready) begin
            m_ready <= 1'b1;
        end else if (m_valid) begin
            if (rx_seen % 48 == 0) begin
                rx_calm = ($urandom_range(0, 2) == 0);
            end
            rx_seen++;
            rx_hold = rx_calm ? 0 : $urandom_range(0, 9);
            if (rx_hold > 0) begin
                m_ready <= 1'b0;
            end
        end
    end

    // Send one request transaction after a random gap; valid stays high
    // when the next transaction follows without a gap.
    task automatic send_item(input opcode_t op, input logic [FLOOR_W-1:0] pickup,
                             input logic [FLOOR_W-1:0] dest);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_opcode       <= op;
        s_pickup_floor <= pickup;
        s_dest_floor   <= dest;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (op == OP_ADD) begin
            adds_sent++;
        end else begin
            ticks_sent++;
        end
    endtask

    task automatic send_tick();
        send_item(OP_TICK, FLOOR_W'($urandom_range(0, 31)), FLOOR_W'($urandom_range(0, 31)));
    endtask

    // Hold off new requests until every predicted status has come back.
    task automatic wait_all_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic write_start_floor(input logic [FLOOR_W-1:0] floor_value);
        wait_all_results();
        repeat (4) @(posedge aclk);
        cfg_valid       <= 1'b1;
        cfg_start_floor <= floor_value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        cfg_writes++;
    endtask

    function automatic logic [FLOOR_W-1:0] near_floor(input int center, input int spread);
        int f;
        f = center + $urandom_range(0, 2 * spread) - spread;
        if (f < 0) begin
            f = 0;
        end else if (f > 31) begin
            f = 31;
        end
        return FLOOR_W'(f);
    endfunction

    // Queue requests that are mostly short trips near a random spot, so the
    // car finishes many of them; some span the building or start and end
    // on the same floor.
    task automatic queue_requests(input int count);
        logic [FLOOR_W-1:0] pickup;
        logic [FLOOR_W-1:0] dest;
        int                 pick;
        repeat (count) begin
            if ($urandom_range(0, 3) == 0) begin
                pickup = FLOOR_W'($urandom_range(0, 31));
            end else begin
                pickup = near_floor($urandom_range(0, 31), 4);
            end
            pick = $urandom_range(0, 7);
            if (pick == 0) begin
                dest = pickup;
            end else if (pick < 3) begin
                dest = FLOOR_W'($urandom_range(0, 31));
            end else begin
                dest = near_floor(pickup, 6);
            end
            send_item(OP_ADD, pickup, dest);
        end
    endtask

    // Random mix of request bursts, tick bursts, overflow bursts, noise and
    // pauses until the phase has sent its share of transactions.
    task automatic run_phase(input int count);
        int target;
        int pick;
        target = items_sent + count;
        while (items_sent < target) begin
            pick    = $urandom_range(0, 99);
            tx_calm = ($urandom_range(0, 3) == 0);
            if (pick < 3) begin
                queue_requests($urandom_range(QUEUE_DEPTH + 1, QUEUE_DEPTH + 4));
            end else if (pick < 28) begin
                queue_requests($urandom_range(1, 3));
            end else if (pick < 33) begin
                send_item(opcode_t'($urandom_range(0, 1)), FLOOR_W'($urandom_range(0, 31)),
                          FLOOR_W'($urandom_range(0, 31)));
            end else if (pick < 35) begin
                wait_all_results();
            end else begin
                repeat ($urandom_range(1, 30)) send_tick();
            end
        end
    endtask

    initial begin
        logic [FLOOR_W-1:0] phase_floor;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty-queue tick, same-floor request, a delivery that
        // retires the next same-floor request in the same tick, extreme floors.
        write_start_floor('0);
        send_tick();
        send_item(OP_ADD, 5'd0, 5'd0);
        send_tick();
        send_item(OP_ADD, 5'd0, 5'd1);
        send_item(OP_ADD, 5'd1, 5'd1);
        send_tick();
        send_tick();
        send_item(OP_ADD, 5'd31, 5'd0);
        send_item(OP_ADD, 5'd0, 5'd31);
        send_item(OP_ADD, 5'd31, 5'd31);
        send_item(OP_ADD, 5'd16, 5'd15);
        send_item(OP_ADD, 5'd15, 5'd16);
        repeat (8) send_tick();

        // Random phases, each with its own start floor, extremes included.
        for (int p = 0; p < 6; p++) begin
            if (p == 0 || p == 4) begin
                phase_floor = 5'd31;
            end else if (p == 2) begin
                phase_floor = 5'd0;
            end else begin
                phase_floor = FLOOR_W'($urandom_range(1, 30));
            end
            write_start_floor(phase_floor);
            run_phase(280);
        end

        wait_all_results();
        repeat (8) @(posedge aclk);

        $display("Run covered %0d request transactions (%0d adds, %0d ticks)",
                 items_sent, adds_sent, ticks_sent);
        $display("with %0d start floor writes and %0d status transactions compared.",
                 cfg_writes, checked);
        if (err_count == 0 && outstanding == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
